@@ hw/rtl/ucd_pkg.sv @@
// ucd_pkg: shared types, codes and constants for the echo-ranging cliff detector.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package ucd_pkg;

  // Field widths
  localparam int unsigned DIST_W  = 19;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned FUNC_W  = 2;

  // Stream widths (tdata padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIST_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE   = 2'd3;

  // Register reset values
  localparam logic [DIST_W-1:0]  LIMIT_RST   = 19'd5120;
  localparam logic [TIMER_W-1:0] TOP_RST     = 16'd65535;
  localparam logic [15:0]        TIMEOUT_RST = 16'd60;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd1114;

  // Arithmetic constants
  localparam logic [DIST_W-1:0] DIST_SAT  = 19'h7FFFF;
  localparam logic [RUN_W-1:0]  RUN_SAT   = 8'd255;
  localparam logic [RUN_W-1:0]  ALARM_RUN = 8'd2;

  // Result bit positions inside m_tdata
  localparam int unsigned OB_TRIG  = 0;
  localparam int unsigned OB_UPD   = 1;
  localparam int unsigned OB_DIST  = 2;
  localparam int unsigned OB_ALARM = OB_DIST + DIST_W;    // 21
  localparam int unsigned OB_STATE = OB_ALARM + 1;        // 22
  localparam int unsigned OB_RUN   = OB_STATE + STATE_W;  // 25
  localparam int unsigned OB_END   = OB_RUN + RUN_W;      // 33

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 2'd0,
    FUNC_CAPTURE = 2'd1,
    FUNC_HANDLE  = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  // Reported state codes
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_RISE = 3'd1;
  localparam logic [STATE_W-1:0] ST_FALL = 3'd2;
  localparam logic [STATE_W-1:0] ST_DONE = 3'd3;
  localparam logic [STATE_W-1:0] ST_TOUT = 3'd4;

  // Measurement phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_RISE = 5'b00010,
    PH_FALL = 5'b00100,
    PH_DONE = 5'b01000,
    PH_TOUT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [DIST_W-1:0]  limit;
    logic [TIMER_W-1:0] top;
    logic [15:0]        timeout;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [TIMER_W-1:0] cap;
    logic [MS_W-1:0]    now;
  } item_t;

  typedef struct packed {
    logic               trig;
    logic               upd;
    logic [DIST_W-1:0]  distance;
    logic               alarm;
    logic [STATE_W-1:0] state;
    logic [RUN_W-1:0]   run;
  } result_t;

  function automatic logic [STATE_W-1:0] phase_code(phase_t ph);
    logic [STATE_W-1:0] code;
    case (ph)
      PH_IDLE: code = ST_IDLE;
      PH_RISE: code = ST_RISE;
      PH_FALL: code = ST_FALL;
      PH_DONE: code = ST_DONE;
      PH_TOUT: code = ST_TOUT;
      default: code = ST_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/ultrasonic_echo_cliff_detector.sv @@
// Top level of the echo-ranging cliff detector: input register, FSM, result register.
// Depends on ucd_pkg, ucd_cfg_regs, ucd_fsm.
`timescale 1ns / 1ps

//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tuser: func; tdata: capture_value, now_ms
//  m_*       | out       | m_tvalid/m_tready  | tdata: flags, distance, state, run count
//  cfg_*     | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
//  One request per cycle sustained while m_tready stays high; a request is taken into the
//  input register, its result into the result register. The FSM and distance multiplier
//  sit between those two registers. The input side keeps accepting while a result waits,
//  as long as the input register is empty or the result register frees up that cycle.
//  rst is synchronous: clears the FSM, both valid flags and loads register defaults.

module ultrasonic_echo_cliff_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ucd_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] capture_value, [47:16] now_ms
  input  logic [ucd_pkg::FUNC_W-1:0]      s_tuser,  // [1:0] func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] trigger_pulse, [1] distance_updated, [20:2] distance_q8, [21] cliff_alarm,
  // [24:22] machine_state, [32:25] unsafe_count, [39:33] zero
  output logic [ucd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [ucd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ucd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ucd_pkg::cfg_t    cfg;
  ucd_pkg::item_t   in_item;
  ucd_pkg::result_t result;
  logic             in_valid;
  logic             out_valid;
  logic             out_free;
  logic             fire;
  logic [ucd_pkg::OUT_DATA_W-1:0] out_data;

  ucd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake: a request moves on when the result register is free or draining
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func <= s_tuser;
      in_item.cap  <= s_tdata[15:0];
      in_item.now  <= s_tdata[47:16];
    end
  end

  ucd_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {7'd0, result.run, result.state, result.alarm, result.distance,
                   result.upd, result.trig};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

@@ hw/rtl/ucd_cfg_regs.sv @@
// ucd_cfg_regs: configuration register file written through the plain write port.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ucd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ucd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ucd_pkg::cfg_t                 cfg
);

  ucd_pkg::cfg_t regs;

  // Register writes take effect on the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.limit   <= ucd_pkg::LIMIT_RST;
      regs.top     <= ucd_pkg::TOP_RST;
      regs.timeout <= ucd_pkg::TIMEOUT_RST;
      regs.scale   <= ucd_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ucd_pkg::CFG_IDX_LIMIT:   regs.limit   <= cfg_wdata;
        ucd_pkg::CFG_IDX_TOP:     regs.top     <= cfg_wdata[15:0];
        ucd_pkg::CFG_IDX_TIMEOUT: regs.timeout <= cfg_wdata[15:0];
        ucd_pkg::CFG_IDX_SCALE:   regs.scale   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ hw/rtl/ucd_dist_calc.sv @@
// ucd_dist_calc: pulse width to distance (cm, Q8) with timer wrap and saturation.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_dist_calc (
  input  logic [ucd_pkg::TIMER_W-1:0] rise_time,
  input  logic [ucd_pkg::TIMER_W-1:0] fall_time,
  input  logic [ucd_pkg::TIMER_W-1:0] top,
  input  logic [ucd_pkg::SCALE_W-1:0] scale,
  output logic [ucd_pkg::DIST_W-1:0]  distance
);

  logic [17:0] up;
  logic [16:0] delta;
  logic [32:0] prod;
  logic [33:0] rounded;
  logic [25:0] shifted;

  // Tick count between edges; timer runs 0..top so wrap is modulo top+1
  always_comb begin
    up = {2'b00, top} + 18'd1 + {2'b00, fall_time};
    if (fall_time >= rise_time) begin
      delta = {1'b0, fall_time} - {1'b0, rise_time};
    end else if (up >= {2'b00, rise_time}) begin
      delta = 17'(up - {2'b00, rise_time});
    end else begin
      // rise capture beyond top+1+fall, only possible above the timer top
      delta = '0;
    end
  end

  // Scale Q16 -> Q8 with round half up, then saturate
  always_comb begin
    prod    = {16'd0, delta} * {17'd0, scale};
    rounded = {1'b0, prod} + 34'd128;
    shifted = rounded[33:8];
    if (|shifted[25:ucd_pkg::DIST_W]) begin
      distance = ucd_pkg::DIST_SAT;
    end else begin
      distance = shifted[ucd_pkg::DIST_W-1:0];
    end
  end

endmodule

@@ hw/rtl/ucd_fsm.sv @@
// ucd_fsm: measurement state machine, capture/launch state and unsafe-run filter.
// Depends on ucd_pkg and ucd_dist_calc.
`timescale 1ns / 1ps

module ucd_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ucd_pkg::item_t    item,
  input  ucd_pkg::cfg_t     cfg,
  output ucd_pkg::result_t  result
);

  ucd_pkg::phase_t              phase, phase_next, phase_chk;
  logic [ucd_pkg::TIMER_W-1:0]  rise_time, rise_time_next;
  logic [ucd_pkg::TIMER_W-1:0]  fall_time, fall_time_next;
  logic [ucd_pkg::MS_W-1:0]     launch_ms, launch_ms_next;
  logic [ucd_pkg::DIST_W-1:0]   last_distance, last_distance_next;
  logic [ucd_pkg::RUN_W-1:0]    bad_run, bad_run_next;
  logic [ucd_pkg::DIST_W-1:0]   pulse_dist;
  logic [ucd_pkg::DIST_W-1:0]   new_dist;
  logic [ucd_pkg::MS_W-1:0]     elapsed;
  logic                         timed_out;
  logic                         trig, upd, alarm;

  ucd_dist_calc u_dist (
    .rise_time (rise_time),
    .fall_time (fall_time),
    .top       (cfg.top),
    .scale     (cfg.scale),
    .distance  (pulse_dist)
  );

  // Wrapping elapsed time since launch
  assign elapsed   = item.now - launch_ms;
  assign timed_out = (elapsed > {16'd0, cfg.timeout});
  assign new_dist  = (phase == ucd_pkg::PH_DONE) ? pulse_dist : cfg.limit;

  // Next-state logic for one request
  always_comb begin
    phase_next         = phase;
    phase_chk          = phase;
    rise_time_next     = rise_time;
    fall_time_next     = fall_time;
    launch_ms_next     = launch_ms;
    last_distance_next = last_distance;
    bad_run_next       = bad_run;
    trig               = 1'b0;
    upd                = 1'b0;
    alarm              = 1'b0;
    case (item.func)
      ucd_pkg::FUNC_START: begin
        // a stale wait is forced into timeout first
        if ((phase == ucd_pkg::PH_RISE || phase == ucd_pkg::PH_FALL) && timed_out) begin
          phase_chk = ucd_pkg::PH_TOUT;
        end
        phase_next = phase_chk;
        if (phase_chk == ucd_pkg::PH_IDLE) begin
          trig           = 1'b1;
          launch_ms_next = item.now;
          phase_next     = ucd_pkg::PH_RISE;
        end
      end
      ucd_pkg::FUNC_CAPTURE: begin
        if (phase == ucd_pkg::PH_RISE) begin
          rise_time_next = item.cap;
          phase_next     = ucd_pkg::PH_FALL;
        end else if (phase == ucd_pkg::PH_FALL) begin
          fall_time_next = item.cap;
          phase_next     = ucd_pkg::PH_DONE;
        end
      end
      ucd_pkg::FUNC_HANDLE: begin
        if (phase == ucd_pkg::PH_DONE || phase == ucd_pkg::PH_TOUT) begin
          last_distance_next = new_dist;
          phase_next         = ucd_pkg::PH_IDLE;
          upd                = 1'b1;
          // unsafe: at or beyond the limit, or a distance of zero
          if (new_dist >= cfg.limit || new_dist == '0) begin
            if (bad_run != ucd_pkg::RUN_SAT) begin
              bad_run_next = bad_run + 8'd1;
            end
            alarm = (bad_run_next >= ucd_pkg::ALARM_RUN);
          end else begin
            bad_run_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers advance once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ucd_pkg::PH_IDLE;
      rise_time     <= '0;
      fall_time     <= '0;
      launch_ms     <= '0;
      last_distance <= '0;
      bad_run       <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      rise_time     <= rise_time_next;
      fall_time     <= fall_time_next;
      launch_ms     <= launch_ms_next;
      last_distance <= last_distance_next;
      bad_run       <= bad_run_next;
    end
  end

  assign result.trig     = trig;
  assign result.upd      = upd;
  assign result.distance = last_distance_next;
  assign result.alarm    = alarm;
  assign result.state    = ucd_pkg::phase_code(phase_next);
  assign result.run      = bad_run_next;

endmodule

@@ hw/rtl/ucd_checker.sv @@
// ucd_checker: port-level assertions for the echo-ranging cliff detector, bound to the top.
// Depends on ucd_pkg and ultrasonic_echo_cliff_detector.
`timescale 1ns / 1ps

module ucd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ucd_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic                          o_trig;
  logic                          o_upd;
  logic                          o_alarm;
  logic [ucd_pkg::STATE_W-1:0]   o_state;
  logic [ucd_pkg::RUN_W-1:0]     o_run;

  assign o_trig  = m_tdata[ucd_pkg::OB_TRIG];
  assign o_upd   = m_tdata[ucd_pkg::OB_UPD];
  assign o_alarm = m_tdata[ucd_pkg::OB_ALARM];
  assign o_state = m_tdata[ucd_pkg::OB_RUN-1:ucd_pkg::OB_STATE];
  assign o_run   = m_tdata[ucd_pkg::OB_END-1:ucd_pkg::OB_RUN];

  // No result is left over from before reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A launched trigger always leaves the machine waiting for the rising edge
  a_trig_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_trig) |-> (o_state == ucd_pkg::ST_RISE && !o_upd && !o_alarm))
    else $error("trigger without wait-rise state");

  // A fresh distance always returns the machine to idle
  a_upd_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_upd) |-> (o_state == ucd_pkg::ST_IDLE))
    else $error("distance update not in idle");

  // Alarm only on an update with at least two unsafe readings in a row
  a_alarm_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_alarm) |-> (o_upd && o_run >= ucd_pkg::ALARM_RUN))
    else $error("alarm without a qualifying unsafe run");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind ultrasonic_echo_cliff_detector ucd_checker u_ucd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_ultrasonic_echo_cliff_detector.sv @@
// Self-checking testbench for the echo-ranging cliff detector: stream driver, result
// monitor and an in-bench model of the ranging state machine. Depends on ucd_pkg and
// the ultrasonic_echo_cliff_detector top level only.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_cliff_detector;
  import ucd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;  // [15:0] capture_value, [47:16] now_ms
  logic [FUNC_W-1:0]     s_tuser   = '0;  // [1:0] func
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [0] trigger, [1] updated, [20:2] distance, [21] alarm, [24:22] state, [32:25] run
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ultrasonic_echo_cliff_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be driven, and readings the ranger must still report
  item_t   request_q[$];
  result_t result_due_q[$];

  // Ranger model: register copy and measurement state
  cfg_t               ranger_cfg   = '{limit: LIMIT_RST, top: TOP_RST,
                                       timeout: TIMEOUT_RST, scale: SCALE_RST};
  logic [STATE_W-1:0] echo_phase   = ST_IDLE;
  logic [TIMER_W-1:0] rise_stamp   = '0;
  logic [TIMER_W-1:0] fall_stamp   = '0;
  logic [MS_W-1:0]    launch_stamp = '0;
  logic [DIST_W-1:0]  range_q8     = '0;
  logic [RUN_W-1:0]   unsafe_run   = '0;

  // Bookkeeping
  int          err_count      = 0;
  int          accepted_count = 0;
  int          result_count   = 0;
  int          update_count   = 0;
  int          alarm_count    = 0;
  int          timeout_count  = 0;
  int          settings_count = 1;
  int          peak_run       = 0;
  logic [31:0] clock_ms       = '0;

  // Control from the sequence to the handshake processes
  logic no_idle       = 1'b0;
  logic long_hold_req = 1'b0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR @%0t %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // One request through the ranger model; returns the reading it must produce
  function automatic result_t step_ranger(logic [FUNC_W-1:0] func, logic [TIMER_W-1:0] cap,
                                          logic [MS_W-1:0] now);
    result_t     r;
    logic [31:0] waited;
    logic [17:0] wrap_span;
    logic [16:0] span;
    logic [63:0] prod;
    r = '0;
    case (func)
      FUNC_START: begin
        waited = now - launch_stamp;
        if ((echo_phase == ST_RISE || echo_phase == ST_FALL) &&
            waited > 32'(ranger_cfg.timeout)) begin
          echo_phase = ST_TOUT;
          timeout_count++;
        end
        if (echo_phase == ST_IDLE) begin
          r.trig       = 1'b1;
          launch_stamp = now;
          echo_phase   = ST_RISE;
        end
      end
      FUNC_CAPTURE: begin
        if (echo_phase == ST_RISE) begin
          rise_stamp = cap;
          echo_phase = ST_FALL;
        end else if (echo_phase == ST_FALL) begin
          fall_stamp = cap;
          echo_phase = ST_DONE;
        end
      end
      FUNC_HANDLE: begin
        if (echo_phase == ST_DONE || echo_phase == ST_TOUT) begin
          if (echo_phase == ST_DONE) begin
            // pulse width with timer wrap at top+1; zero if the rise capture lies beyond top+1+fall
            if (fall_stamp >= rise_stamp) begin
              span = 17'(fall_stamp) - 17'(rise_stamp);
            end else begin
              wrap_span = 18'(ranger_cfg.top) + 18'd1 + 18'(fall_stamp);
              span = (wrap_span >= 18'(rise_stamp)) ? 17'(wrap_span - 18'(rise_stamp)) : '0;
            end
            prod = (64'(span) * 64'(ranger_cfg.scale) + 64'd128) >> 8;
            range_q8 = (prod > 64'(DIST_SAT)) ? DIST_SAT : prod[DIST_W-1:0];
          end else begin
            range_q8 = ranger_cfg.limit;
          end
          echo_phase = ST_IDLE;
          r.upd      = 1'b1;
          if (range_q8 >= ranger_cfg.limit || range_q8 == '0) begin
            if (unsafe_run < RUN_SAT) unsafe_run++;
            if (unsafe_run >= ALARM_RUN) r.alarm = 1'b1;
          end else begin
            unsafe_run = '0;
          end
        end
      end
      default: ;
    endcase
    r.distance = range_q8;
    r.state    = echo_phase;
    r.run      = unsafe_run;
    return r;
  endfunction

  // Driver: presents queued requests, random gaps between them unless no_idle is set
  always @(posedge clk) begin : driver
    static int gap_left = 0;
    item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        result_due_q.push_back(step_ranger(s_tuser, s_tdata[15:0], s_tdata[47:16]));
        accepted_count++;
        if (!no_idle && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          it = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {it.now, it.cap};
          s_tuser  <= it.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts unless no_idle is set, plus one long hold-off so the input backs up
  always @(posedge clk) begin : receiver
    static int   stall_left = 0;
    static int   hold_left  = 0;
    static logic hold_taken = 1'b0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: every accepted reading against the oldest one due
  always @(posedge clk) begin : monitor
    result_t due;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (result_due_q.size() == 0) begin
        report_mismatch("reading with none due", 64'(m_tdata), '0);
      end else begin
        due = result_due_q.pop_front();
        if (m_tdata[OB_TRIG] !== due.trig)
          report_mismatch("trigger_pulse", 64'(m_tdata[OB_TRIG]), 64'(due.trig));
        if (m_tdata[OB_UPD] !== due.upd)
          report_mismatch("distance_updated", 64'(m_tdata[OB_UPD]), 64'(due.upd));
        if (m_tdata[OB_DIST +: DIST_W] !== due.distance)
          report_mismatch("distance_q8", 64'(m_tdata[OB_DIST +: DIST_W]),
                          64'(due.distance));
        if (m_tdata[OB_ALARM] !== due.alarm)
          report_mismatch("cliff_alarm", 64'(m_tdata[OB_ALARM]), 64'(due.alarm));
        if (m_tdata[OB_STATE +: STATE_W] !== due.state)
          report_mismatch("machine_state", 64'(m_tdata[OB_STATE +: STATE_W]), 64'(due.state));
        if (m_tdata[OB_RUN +: RUN_W] !== due.run)
          report_mismatch("unsafe_count", 64'(m_tdata[OB_RUN +: RUN_W]), 64'(due.run));
        if (m_tdata[OUT_DATA_W-1:OB_END] !== '0)
          report_mismatch("padding", 64'(m_tdata[OUT_DATA_W-1:OB_END]), '0);
        if (due.upd) update_count++;
        if (due.alarm) alarm_count++;
        if (int'(due.run) > peak_run) peak_run = int'(due.run);
      end
    end
  end

  // Watchdog: too long without any handshake while work is outstanding
  always @(posedge clk) begin : watchdog
    static int quiet_cycles = 0;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we ||
          (request_q.size() == 0 && result_due_q.size() == 0 && !s_tvalid))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("FAIL ultrasonic_echo_cliff_detector");
        $finish;
      end
    end
  end

  task automatic push_request(logic [FUNC_W-1:0] f, logic [TIMER_W-1:0] c, logic [MS_W-1:0] n);
    item_t it;
    it.func = f;
    it.cap  = c;
    it.now  = n;
    request_q.push_back(it);
  endtask

  // Wait until the ranger has reported everything it was given
  task automatic wait_quiet();
    while (request_q.size() != 0 || s_tvalid || result_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes, back to back, only while the ranger is idle
  task automatic apply_config(cfg_t c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_LIMIT;
    cfg_wdata <= c.limit;
    @(posedge clk);
    cfg_index <= CFG_IDX_TOP;
    cfg_wdata <= CFG_DATA_W'(c.top);
    @(posedge clk);
    cfg_index <= CFG_IDX_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(c.timeout);
    @(posedge clk);
    cfg_index <= CFG_IDX_SCALE;
    cfg_wdata <= CFG_DATA_W'(c.scale);
    @(posedge clk);
    cfg_we <= 1'b0;
    ranger_cfg = c;
    settings_count++;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.limit   = DIST_W'($urandom_range(0, 285184));
    c.top     = 16'($urandom_range(1, 65535));
    c.timeout = $urandom_range(0, 1) ? 16'($urandom_range(1, 200))
                                     : 16'($urandom_range(1, 65535));
    c.scale   = 16'($urandom);
    return c;
  endfunction

  // One measurement: start, maybe a late restart, rise and fall captures, handle, with some noise.
  // The quick form always times out and so needs only three requests.
  task automatic add_measurement(bit quick);
    logic [31:0]        launch;
    logic [31:0]        waited;
    logic [TIMER_W-1:0] rise;
    logic [TIMER_W-1:0] fall;
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 40);
    launch = clock_ms;
    push_request(FUNC_START, 16'($urandom), launch);
    if (quick || $urandom_range(0, 6) == 0) begin
      // restart right around the timeout boundary
      waited = quick ? 32'(ranger_cfg.timeout) + $urandom_range(1, 3)
                     : 32'(ranger_cfg.timeout) + $urandom_range(0, 3) - 1;
      clock_ms = launch + waited;
      push_request(FUNC_START, 16'($urandom), clock_ms);
      if (waited > 32'(ranger_cfg.timeout)) begin
        push_request(FUNC_HANDLE, 16'($urandom), $urandom);
        return;
      end
    end
    if ($urandom_range(0, 7) == 0)
      push_request(FUNC_W'($urandom_range(0, 3)), 16'($urandom), clock_ms);
    rise = 16'($urandom);
    push_request(FUNC_CAPTURE, rise, $urandom);
    if ($urandom_range(0, 9) == 0)
      push_request(FUNC_START, 16'($urandom),
                   launch + $urandom_range(0, 2 * int'(ranger_cfg.timeout) + 2));
    case ($urandom_range(0, 4))
      0: fall = 16'($urandom);
      1: fall = rise + 16'($urandom_range(0, 1500));
      2: fall = rise;
      3: fall = rise - 16'($urandom_range(1, 50));
      default: fall = 16'($urandom_range(0, int'(ranger_cfg.top)));
    endcase
    push_request(FUNC_CAPTURE, fall, $urandom);
    if ($urandom_range(0, 9) == 0)
      push_request(FUNC_W'($urandom_range(0, 3)), 16'($urandom), clock_ms);
    push_request(FUNC_HANDLE, 16'($urandom), $urandom);
  endtask

  // Test sequence
  initial begin
    cfg_t c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: stray requests, wrap, zero width, timeouts, alarm run
    push_request(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);    // unused kind
    push_request(FUNC_CAPTURE, 16'hFFFF, 32'd0);           // capture while idle
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);            // handle while idle
    push_request(FUNC_START, 16'h0000, 32'hFFFF_FFFF);
    push_request(FUNC_START, 16'h0000, 32'd59);            // wait equals limit, no timeout
    push_request(FUNC_CAPTURE, 16'hFFFF, 32'd0);
    push_request(FUNC_START, 16'h0000, 32'd59);            // start while waiting for fall
    push_request(FUNC_CAPTURE, 16'h0000, 32'd0);           // wraps past top
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);            // small, safe reading
    push_request(FUNC_START, 16'h0000, 32'd100);
    push_request(FUNC_CAPTURE, 16'd500, 32'd0);
    push_request(FUNC_CAPTURE, 16'd500, 32'd0);
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);            // zero distance, unsafe
    push_request(FUNC_START, 16'h0000, 32'd200);
    push_request(FUNC_START, 16'h0000, 32'd261);           // timeout waiting for rise
    push_request(FUNC_CAPTURE, 16'd7, 32'd0);              // capture during timeout
    push_request(FUNC_START, 16'h0000, 32'd300);           // start during timeout
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);            // limit used, alarm
    push_request(FUNC_START, 16'h0000, 32'd400);
    push_request(FUNC_CAPTURE, 16'h0000, 32'd0);
    push_request(FUNC_CAPTURE, 16'hFFFF, 32'd0);
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);            // widest pulse
    push_request(FUNC_START, 16'h0000, 32'd500);
    push_request(FUNC_CAPTURE, 16'd10, 32'd0);
    push_request(FUNC_START, 16'h0000, 32'd561);           // timeout waiting for fall
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);
    wait_quiet();

    // Random registers; receiver holds off once so the input side backs up
    apply_config(random_cfg());
    long_hold_req <= 1'b1;
    repeat (40) add_measurement(1'b0);
    wait_quiet();

    // Narrow timer, full scale, top limit, shortest timeout
    c = '{limit: DIST_W'(285184), top: 16'd1, timeout: 16'd1, scale: 16'hFFFF};
    apply_config(c);
    push_request(FUNC_START, 16'h0000, clock_ms);
    push_request(FUNC_CAPTURE, 16'd100, 32'd0);
    push_request(FUNC_CAPTURE, 16'd5, 32'd0);              // capture beyond top
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);
    push_request(FUNC_START, 16'h0000, clock_ms);
    push_request(FUNC_CAPTURE, 16'h0000, 32'd0);
    push_request(FUNC_CAPTURE, 16'hFFFF, 32'd0);           // distance saturates
    push_request(FUNC_HANDLE, 16'h0000, 32'd0);
    repeat (30) add_measurement(1'b0);
    wait_quiet();

    // Zero limit and zero scale: every reading unsafe, run count saturates
    c = '{limit: '0, top: 16'hFFFF, timeout: 16'hFFFF, scale: 16'h0000};
    apply_config(c);
    repeat (260) add_measurement(1'b1);
    repeat (10) add_measurement(1'b0);
    wait_quiet();

    apply_config(random_cfg());
    repeat (30) add_measurement(1'b0);
    wait_quiet();

    // Reset values again, both sides running flat out
    c = '{limit: LIMIT_RST, top: TOP_RST, timeout: TIMEOUT_RST, scale: SCALE_RST};
    apply_config(c);
    no_idle <= 1'b1;
    repeat (25) add_measurement(1'b0);
    wait_quiet();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests and %0d readings over %0d register settings,",
             accepted_count, result_count, settings_count);
    $display("with %0d distance updates, %0d cliff alarms, %0d timeouts, peak unsafe run %0d.",
             update_count, alarm_count, timeout_count, peak_run);
    if (err_count == 0) begin
      $display("PASS ultrasonic_echo_cliff_detector");
    end else begin
      $display("FAIL ultrasonic_echo_cliff_detector");
    end
    $finish;
  end

endmodule

@@ ultrasonic_echo_cliff_detector.f @@
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_cfg_regs.sv
hw/rtl/ucd_dist_calc.sv
hw/rtl/ucd_fsm.sv
hw/rtl/ultrasonic_echo_cliff_detector.sv
hw/rtl/ucd_checker.sv
tb/tb_ultrasonic_echo_cliff_detector.sv
